// ===== rtl/core/sobel_pkg.sv =====
package sobel_pkg;

    localparam int MaxWidth    = 1024;
    localparam int ColW        = $clog2(MaxWidth);
    localparam int PixW        = 24;
    localparam int RowW        = 16;
    localparam int CfgW        = 16;
    localparam int CfgIdxW     = 1;
    localparam int QDepth      = 4;
    localparam int QPtrW       = $clog2(QDepth);

    localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'd0;
    localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'd1;

    // one 3x3 window with its result position
    typedef struct packed {
        logic [8:0][PixW-1:0] win;
        logic [RowW-1:0]      row;
        logic [ColW-1:0]      col;
        logic                 done;
    } t_job;

    // result transaction
    typedef struct packed {
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
        logic            done;
    } t_result;

    // queue status toward the front
    typedef struct packed {
        logic full;
        logic almost_full;
    } t_qstat;

endpackage

// ===== rtl/core/sobel_ram.sv =====
module sobel_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/sobel_front.sv =====
module sobel_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sobel_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [sobel_pkg::CfgW-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_pixel_red,
    input  logic [7:0]                 i_pixel_green,
    input  logic [7:0]                 i_pixel_blue,
    input  sobel_pkg::t_qstat          i_qstat,
    output logic                       o_job_valid,
    output sobel_pkg::t_job            o_job
);
    import sobel_pkg::*;

    logic [10:0]       r_width;
    logic [RowW-1:0]   r_height;
    logic [ColW-1:0]   r_col;
    logic [RowW-1:0]   r_row;
    logic [ColW-1:0]   n_col;
    logic [RowW-1:0]   n_row;
    logic [11:0]       eff_w;
    logic [RowW-1:0]   eff_h;
    logic              acc;
    logic [PixW-1:0]   px;
    logic [PixW-1:0]   top;
    logic [PixW-1:0]   mid;

    // stage 1: accepted pixel and the centre position of its window, waiting on line reads
    logic              r_s1_v;
    logic [PixW-1:0]   r_s1_px;
    logic [RowW-1:0]   r_s1_row;
    logic [ColW-1:0]   r_s1_col;
    logic              r_s1_emit;
    logic              r_s1_done;
    logic [2:0][PixW-1:0] r_wa;
    logic [2:0][PixW-1:0] r_wb;

    logic              emit;
    logic              done;

    // accept while the queue has room for this and one in flight
    assign o_ready = !i_qstat.almost_full;
    assign acc     = i_valid && o_ready;
    assign px      = {i_pixel_red, i_pixel_green, i_pixel_blue};

    // effective frame size
    always_comb begin
        if (r_width < 11'd3) begin
            eff_w = 12'd3;
        end else if ({1'b0, r_width} > 12'(MaxWidth)) begin
            eff_w = 12'(MaxWidth);
        end else begin
            eff_w = {1'b0, r_width};
        end
        eff_h = (r_height < 16'd3) ? 16'd3 : r_height;
    end

    // classify the pixel
    assign emit = (r_row >= 16'd2) && (r_col >= ColW'(2)) && (r_row < eff_h)
               && ({2'b0, r_col} < eff_w);
    assign done = (r_row == eff_h - 16'd1) && ({2'b0, r_col} == eff_w - 12'd1);

    // raster position
    always_comb begin
        if ({2'b0, r_col} + 12'd1 >= eff_w) begin
            n_col = '0;
            n_row = ({1'b0, r_row} + 17'd1 >= {1'b0, eff_h}) ? '0 : r_row + 16'd1;
        end else begin
            n_col = r_col + ColW'(1);
            n_row = r_row;
        end
    end

    // configuration registers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd640;
            r_height <= 16'd480;
            r_col    <= '0;
            r_row    <= '0;
            r_s1_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    RegFrameWidth:  r_width  <= i_cfg_data[10:0];
                    RegFrameHeight: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_v <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px   <= px;
            r_s1_row  <= r_row - 16'd1;
            r_s1_col  <= r_col - ColW'(1);
            r_s1_emit <= emit;
            r_s1_done <= done;
        end
    end

    // line stores, read on accept, written in the following cycle
    sobel_ram #(.Width(PixW), .Depth(MaxWidth)) u_line_above (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_col + ColW'(1)),
        .i_wdata (r_s1_px),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (mid)
    );

    sobel_ram #(.Width(PixW), .Depth(MaxWidth)) u_line_two (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_col + ColW'(1)),
        .i_wdata (mid),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (top)
    );

    // window columns: wa two back, wb one back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa <= '0;
            r_wb <= '0;
        end else if (r_s1_v) begin
            r_wa <= r_wb;
            r_wb <= {r_s1_px, mid, top};
        end
    end

    // job to the queue
    assign o_job_valid = r_s1_v && r_s1_emit;
    assign o_job.win   = {r_s1_px, mid, top, r_wb, r_wa};
    assign o_job.row   = r_s1_row;
    assign o_job.col   = r_s1_col;
    assign o_job.done  = r_s1_done;
endmodule

// ===== rtl/core/sobel_queue.sv =====
module sobel_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sobel_pkg::t_job   i_job,
    output sobel_pkg::t_qstat o_qstat,
    output logic              o_valid,
    input  logic              i_pop,
    output sobel_pkg::t_job   o_job
);
    import sobel_pkg::*;

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wp;
    logic [QPtrW-1:0] r_rp;
    logic [QPtrW:0]   r_cnt;
    logic             pop;

    assign pop             = i_pop && (r_cnt != '0);
    assign o_valid         = (r_cnt != '0);
    assign o_job           = r_mem[r_rp];
    assign o_qstat.full        = (r_cnt == (QPtrW+1)'(QDepth));
    // room kept for the transaction still in the line read stage
    assign o_qstat.almost_full = (r_cnt >= (QPtrW+1)'(QDepth - 1));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPtrW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QPtrW'(1);
            end
            r_cnt <= r_cnt + (QPtrW+1)'(i_push) - (QPtrW+1)'(pop);
        end
    end
endmodule

// ===== rtl/core/sobel_back.sv =====
module sobel_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  sobel_pkg::t_job    i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output sobel_pkg::t_result o_res
);
    import sobel_pkg::*;

    // pipeline: gradients, squares, sum, then 8 root steps, then output
    localparam int NStg = 12;

    logic [NStg-2:0]   r_v;
    logic              adv;
    logic [8:0][PixW-1:0] w;

    logic [2:0][10:0]  r_gx;
    logic [2:0][10:0]  r_gy;
    logic [2:0][19:0]  r_sx;
    logic [2:0][19:0]  r_sy;
    logic [2:0][20:0]  r_sum;
    logic [7:0][2:0][20:0] r_rem;
    logic [7:0][2:0][7:0]  r_root;
    logic [NStg-2:0][RowW-1:0] r_row;
    logic [NStg-2:0][ColW-1:0] r_col;
    logic [NStg-2:0]           r_done;
    logic [2:0][20:0]  rem_in [8];
    logic [2:0][7:0]   root_in [8];
    t_result           r_out;
    logic              r_out_v;

    // pipeline moves when the output slot is free or being taken
    assign adv   = !r_out_v || i_ready;
    assign o_pop = adv && i_valid;
    assign w     = i_job.win;

    function automatic logic [10:0] gradx(input logic [8:0][PixW-1:0] x, input int s);
        logic [10:0] a;
        logic [10:0] b;
        a = 11'(x[6][s+:8]) + 11'({x[7][s+:8], 1'b0}) + 11'(x[8][s+:8]);
        b = 11'(x[0][s+:8]) + 11'({x[1][s+:8], 1'b0}) + 11'(x[2][s+:8]);
        return a - b;
    endfunction

    function automatic logic [10:0] grady(input logic [8:0][PixW-1:0] x, input int s);
        logic [10:0] a;
        logic [10:0] b;
        a = 11'(x[2][s+:8]) + 11'({x[5][s+:8], 1'b0}) + 11'(x[8][s+:8]);
        b = 11'(x[0][s+:8]) + 11'({x[3][s+:8], 1'b0}) + 11'(x[6][s+:8]);
        return a - b;
    endfunction

    function automatic logic [9:0] absv(input logic [10:0] v);
        logic [10:0] n;
        n = v[10] ? (~v + 11'd1) : v;
        return n[9:0];
    endfunction

    // window order: column-major, a then b then new, each top/mid/bottom
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                r_gx[c] <= gradx(w, 16 - 8 * c);
                r_gy[c] <= grady(w, 16 - 8 * c);
                r_sx[c] <= 20'(absv(r_gx[c])) * 20'(absv(r_gx[c]));
                r_sy[c] <= 20'(absv(r_gy[c])) * 20'(absv(r_gy[c]));
                r_sum[c] <= 21'(r_sx[c]) + 21'(r_sy[c]);
            end
            r_row[0]  <= i_job.row;
            r_col[0]  <= i_job.col;
            r_done[0] <= i_job.done;
            for (int k = 1; k < NStg - 1; k++) begin
                r_row[k]  <= r_row[k-1];
                r_col[k]  <= r_col[k-1];
                r_done[k] <= r_done[k-1];
            end
        end
    end

    // restoring root, one result bit per stage
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            for (int c = 0; c < 3; c++) begin
                rem_in[k][c]  = (k == 0) ? r_sum[c] : r_rem[k-1][c];
                root_in[k][c] = (k == 0) ? 8'd0 : r_root[k-1][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 8; k++) begin
                for (int c = 0; c < 3; c++) begin
                    logic [7:0]  t;
                    logic [20:0] sq;
                    t  = root_in[k][c] | (8'd1 << (7 - k));
                    sq = 21'(t) * 21'(t);
                    if (rem_in[k][c] >= 21'd65536) begin
                        r_root[k][c] <= 8'd255;
                    end else if (sq <= rem_in[k][c]) begin
                        r_root[k][c] <= t;
                    end else begin
                        r_root[k][c] <= root_in[k][c];
                    end
                    r_rem[k][c] <= rem_in[k][c];
                end
            end
        end
    end

    // valid chain and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_v     <= {r_v[NStg-3:0], o_pop};
            r_out_v <= r_v[NStg-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.red   <= r_root[7][0];
            r_out.green <= r_root[7][1];
            r_out.blue  <= r_root[7][2];
            r_out.row   <= r_row[NStg-2];
            r_out.col   <= r_col[NStg-2];
            r_out.done  <= r_done[NStg-2];
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
endmodule

// ===== rtl/core/sobel_edge_magnitude_rgb.sv =====
// path: pixel transaction, line read stage, window queue, back-end pipeline, output register
// throughput: one pixel per cycle while no output stall fills the queue, set by the line
// store port and the pipelined back end
// backpressure: a four-entry queue between front and back absorbs output stalls
// reset: synchronous active-low; counters, window and valid flags clear,
// frame size returns to 640x480, line stores keep their contents
module sobel_edge_magnitude_rgb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sobel_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [sobel_pkg::CfgW-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_pixel_red,
    input  logic [7:0]                    i_pixel_green,
    input  logic [7:0]                    i_pixel_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_edge_red,
    output logic [7:0]                    o_edge_green,
    output logic [7:0]                    o_edge_blue,
    output logic [15:0]                   o_centre_row,
    output logic [9:0]                    o_centre_col,
    output logic                          o_frame_done
);
    import sobel_pkg::*;

    t_qstat  qstat;
    logic    job_v;
    t_job    job;
    logic    q_v;
    logic    q_pop;
    t_job    q_job;
    t_result res;

    // front: counters, line stores, window
    sobel_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_pixel_red, .i_pixel_green, .i_pixel_blue,
        .i_qstat     (qstat),
        .o_job_valid (job_v),
        .o_job       (job)
    );

    // window queue
    sobel_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (job_v),
        .i_job   (job),
        .o_qstat (qstat),
        .o_valid (q_v),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    // back: gradients and magnitudes
    sobel_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (q_v),
        .o_pop   (q_pop),
        .i_job   (q_job),
        .o_valid,
        .i_ready,
        .o_res   (res)
    );

    assign o_edge_red   = res.red;
    assign o_edge_green = res.green;
    assign o_edge_blue  = res.blue;
    assign o_centre_row = res.row;
    assign o_centre_col = res.col;
    assign o_frame_done = res.done;
endmodule

// ===== rtl/core/sobel_checker.sv =====
module sobel_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_centre_row,
    input logic [9:0]  o_centre_col,
    input logic        o_frame_done
);
    // stalled result stays valid and keeps its position
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_centre_row) && $stable(o_centre_col))
        else $error("result changed while stalled");

    // no centre on the first row or column
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_centre_col != 10'd0 && o_centre_row != 16'd0)
        else $error("border centre reported");

    // no output right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");

    // frame end implies a centre off the first column
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_centre_col != 10'd0)
        else $error("bad frame end");

    // a waiting pixel transaction stays offered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("pixel withdrawn while waiting");
endmodule

bind sobel_edge_magnitude_rgb sobel_checker u_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
    .o_centre_row, .o_centre_col, .o_frame_done
);

// ===== bench/sobel_edge_magnitude_rgb_test.sv =====
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb_test;
    import sobel_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int DrainCycles = 40;

    // gradient magnitude predictor and store of pending results
    class edge_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        logic [PixW-1:0] above [MaxWidth];
        logic [PixW-1:0] two_above [MaxWidth];
        logic [PixW-1:0] back2 [3];
        logic [PixW-1:0] back1 [3];
        int unsigned row_cnt;
        int unsigned col_cnt;
        t_result expected_q [$];
        int errors;

        function new();
            errors = 0;
            reset_state();
        endfunction

        function void reset_state();
            width_reg = 640;
            height_reg = 480;
            for (int k = 0; k < 3; k++) begin
                back2[k] = '0;
                back1[k] = '0;
            end
            for (int k = 0; k < MaxWidth; k++) begin
                above[k] = '0;
                two_above[k] = '0;
            end
            row_cnt = 0;
            col_cnt = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
            if (idx == RegFrameWidth) width_reg = data & 16'h07ff;
            else height_reg = data;
        endfunction

        // floor sqrt of gx^2 + gy^2 over one channel, saturated at 255
        function logic [7:0] channel_mag(logic [PixW-1:0] win [9], int ch);
            int p [9];
            int gx;
            int gy;
            int sumsq;
            int s;
            for (int k = 0; k < 9; k++) p[k] = (win[k] >> (16 - 8 * ch)) & 8'hff;
            gx = -p[0] + p[2] - 2 * p[3] + 2 * p[5] - p[6] + p[8];
            gy = -p[0] - 2 * p[1] - p[2] + p[6] + 2 * p[7] + p[8];
            sumsq = gx * gx + gy * gy;
            if (sumsq >= 65536) return 8'd255;
            s = 0;
            while ((s + 1) * (s + 1) <= sumsq) s++;
            return s[7:0];
        endfunction

        function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            int unsigned w;
            int unsigned h;
            logic [PixW-1:0] px;
            logic [PixW-1:0] top;
            logic [PixW-1:0] mid;
            logic [PixW-1:0] win [9];
            t_result res;
            w = width_reg < 3 ? 3 : (width_reg > MaxWidth ? MaxWidth : width_reg);
            h = height_reg < 3 ? 3 : height_reg;
            px = {red, green, blue};
            top = two_above[col_cnt];
            mid = above[col_cnt];
            // interior centre: one result
            if (row_cnt >= 2 && col_cnt >= 2 && row_cnt < h && col_cnt < w) begin
                for (int l = 0; l < 3; l++) begin
                    win[3 * l] = back2[l];
                    win[3 * l + 1] = back1[l];
                end
                win[2] = top;
                win[5] = mid;
                win[8] = px;
                res.red = channel_mag(win, 0);
                res.green = channel_mag(win, 1);
                res.blue = channel_mag(win, 2);
                res.row = RowW'(row_cnt - 1);
                res.col = ColW'(col_cnt - 1);
                res.done = (row_cnt == h - 1) && (col_cnt == w - 1);
                expected_q.push_back(res);
            end
            back2 = back1;
            back1[0] = top;
            back1[1] = mid;
            back1[2] = px;
            two_above[col_cnt] = mid;
            above[col_cnt] = px;
            if (col_cnt + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (row_cnt + 1 >= h) ? 0 : ((row_cnt + 1) & 16'hffff);
            end else begin
                col_cnt = col_cnt + 1;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.red !== exp_res.red) begin
                $display("%0t: edge_red expected %0d actual %0d", $time, exp_res.red, got.red);
                errors++;
            end
            if (got.green !== exp_res.green) begin
                $display("%0t: edge_green expected %0d actual %0d", $time,
                         exp_res.green, got.green);
                errors++;
            end
            if (got.blue !== exp_res.blue) begin
                $display("%0t: edge_blue expected %0d actual %0d", $time,
                         exp_res.blue, got.blue);
                errors++;
            end
            if (got.row !== exp_res.row) begin
                $display("%0t: centre_row expected %0d actual %0d", $time,
                         exp_res.row, got.row);
                errors++;
            end
            if (got.col !== exp_res.col) begin
                $display("%0t: centre_col expected %0d actual %0d", $time,
                         exp_res.col, got.col);
                errors++;
            end
            if (got.done !== exp_res.done) begin
                $display("%0t: frame_done expected %0b actual %0b", $time,
                         exp_res.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [CfgW-1:0] i_cfg_data;
    logic i_valid;
    logic o_ready;
    logic [7:0] i_pixel_red;
    logic [7:0] i_pixel_green;
    logic [7:0] i_pixel_blue;
    logic o_valid;
    logic i_ready;
    logic [7:0] o_edge_red;
    logic [7:0] o_edge_green;
    logic [7:0] o_edge_blue;
    logic [15:0] o_centre_row;
    logic [9:0] o_centre_col;
    logic o_frame_done;

    edge_scoreboard sb;
    bit idling_on;
    int stall_left;
    int cycle_cnt;

    sobel_edge_magnitude_rgb uut (.*);

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // cycle limit
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // output stall bursts
    initial stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready = 1'b0;
            stall_left--;
        end else begin
            i_ready = 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_edge_red, o_edge_green, o_edge_blue,
                             o_centre_row, o_centre_col, o_frame_done});
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // one pixel transaction, with an optional idle burst first
    task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pixel_red = red;
        i_pixel_green = green;
        i_pixel_blue = blue;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(red, green, blue);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // whole frames of random content
    task automatic random_frames(int w, int h, int frames);
        for (int f = 0; f < frames * w * h; f++)
            send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    initial begin
        sb = new();
        idling_on = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = RegFrameWidth;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b1;
        i_pixel_red = '0;
        i_pixel_green = '0;
        i_pixel_blue = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // undersized registers clamp to a 3x3 frame
        write_reg(RegFrameWidth, 16'd0);
        write_reg(RegFrameHeight, 16'd2);
        // steps saturate, checkerboard and flat frames give zero
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_pixel(c == 2 ? 8'd255 : 8'd0, r == 2 ? 8'd255 : 8'd0,
                           ((r + c) % 2) ? 8'd255 : 8'd0);
        for (int k = 0; k < 9; k++) send_pixel(8'd255, 8'd255, 8'd255);
        for (int k = 0; k < 9; k++) send_pixel(8'd0, 8'd0, 8'd0);
        idling_on = 1'b1;
        random_frames(3, 3, 1);
        wait_idle();

        // oversized width clamps to the line store depth: one row wraps there,
        // then the frame ends at a narrow width so the wrap shows in the rows
        write_reg(RegFrameWidth, 16'd2047);
        write_reg(RegFrameHeight, 16'd1);
        random_frames(MaxWidth, 1, 1);
        wait_idle();
        write_reg(RegFrameWidth, 16'd6);
        random_frames(6, 2, 1);
        wait_idle();

        // random small frame sizes
        for (int n = 0; n < 300;) begin
            int w;
            int h;
            int frames;
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 9);
            frames = $urandom_range(1, 3);
            write_reg(RegFrameWidth, CfgW'(w));
            write_reg(RegFrameHeight, CfgW'(h));
            random_frames(w, h, frames);
            n += w * h * frames;
            wait_idle();
        end

        // tallest frame height, first 30 rows only, no idling
        idling_on = 1'b0;
        write_reg(RegFrameWidth, 16'd3);
        write_reg(RegFrameHeight, 16'd65535);
        random_frames(3, 30, 1);
        wait_idle();

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/sobel_pkg.sv
rtl/core/sobel_ram.sv
rtl/core/sobel_front.sv
rtl/core/sobel_queue.sv
rtl/core/sobel_back.sv
rtl/core/sobel_edge_magnitude_rgb.sv
rtl/core/sobel_checker.sv
bench/sobel_edge_magnitude_rgb_test.sv
